[sv/jcbp_pkg.sv]
// shared types and constants for the controller command block processor
package jcbp_pkg;

  localparam int BLOCK_BYTES     = 64;
  localparam int MAX_CONTROLLERS = 4;
  localparam int IDX_W           = $clog2(BLOCK_BYTES);
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BLOCK_BYTES - 1);

  localparam logic [7:0] CODE_SKIP  = 8'h00;
  localparam logic [7:0] CODE_END_A = 8'hFD;
  localparam logic [7:0] CODE_END_B = 8'hFE;
  localparam logic [7:0] CODE_PAD_A = 8'hFF;
  localparam logic [7:0] CODE_PAD_B = 8'hB4;
  localparam logic [7:0] CODE_PAD_C = 8'h56;
  localparam logic [7:0] CODE_PAD_D = 8'hB8;
  localparam logic [7:0] CMD_INFO   = 8'h00;
  localparam logic [7:0] CMD_INFO_B = 8'hFF;
  localparam logic [7:0] CMD_READ   = 8'h01;
  localparam logic [7:0] RX_MASK    = 8'h3F;
  localparam logic [7:0] CTRL_OK    = 8'h08;
  localparam logic [7:0] CTRL_MAX   = 8'h01;
  localparam logic [7:0] ID_BYTE0   = 8'h05;
  localparam logic [7:0] ID_BYTE1   = 8'h00;
  localparam logic [7:0] ID_BYTE2   = 8'h01;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_CHANNEL = 2'd2,
    ERR_CONTROL = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_END,
    CLS_PAD,
    CLS_OPEN
  } cls_t;

  typedef enum logic [1:0] {
    KIND_INFO,
    KIND_READ,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    logic [7:0] block_byte;
    logic [7:0] buttons_high;
    logic [7:0] buttons_low;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    cls_t     cls;
    kind_t    kind;
    logic     bad_ctrl;
  } cls_item_t;

endpackage

[sv/jcbp_front.sv]
// front end: accepts block bytes, classifies them and queues them for the parser
module jcbp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  jcbp_pkg::in_item_t   in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output jcbp_pkg::cls_item_t  q_item
);

  jcbp_pkg::cls_item_t             mem_r [jcbp_pkg::QUEUE_DEPTH];
  logic [jcbp_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [jcbp_pkg::QCNT_W-1:0]     cnt_r;
  jcbp_pkg::cls_item_t             cls_item;
  logic                            push, pop;
  logic [7:0]                      b;

  assign b = in_item.block_byte;

  always_comb begin
    cls_item.item = in_item;
    if (b == jcbp_pkg::CODE_SKIP) begin
      cls_item.cls = jcbp_pkg::CLS_SKIP;
    end else if (b == jcbp_pkg::CODE_END_A || b == jcbp_pkg::CODE_END_B) begin
      cls_item.cls = jcbp_pkg::CLS_END;
    end else if (b == jcbp_pkg::CODE_PAD_A || b == jcbp_pkg::CODE_PAD_B ||
                 b == jcbp_pkg::CODE_PAD_C || b == jcbp_pkg::CODE_PAD_D) begin
      cls_item.cls = jcbp_pkg::CLS_PAD;
    end else begin
      cls_item.cls = jcbp_pkg::CLS_OPEN;
    end
    if (b == jcbp_pkg::CMD_INFO || b == jcbp_pkg::CMD_INFO_B) begin
      cls_item.kind = jcbp_pkg::KIND_INFO;
    end else if (b == jcbp_pkg::CMD_READ) begin
      cls_item.kind = jcbp_pkg::KIND_READ;
    end else begin
      cls_item.kind = jcbp_pkg::KIND_OTHER;
    end
    cls_item.bad_ctrl = (b > jcbp_pkg::CTRL_MAX) && (b != jcbp_pkg::CTRL_OK);
  end

  assign in_full = (cnt_r == jcbp_pkg::QCNT_W'(jcbp_pkg::QUEUE_DEPTH));
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign pop     = q_valid && q_ready;
  assign q_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[sv/jcbp_back.sv]
// back end: frame parser, response insertion and result queue
module jcbp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  jcbp_pkg::cls_item_t  q_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output jcbp_pkg::out_item_t  out_item
);

  logic                         present_r;
  logic [jcbp_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [2:0]                   chan_r, chan_nxt;
  logic [6:0]                   off_r, off_nxt;
  logic [7:0]                   len_r, len_nxt;
  jcbp_pkg::kind_t              kind_r, kind_nxt;
  logic                         done_r, done_nxt;

  jcbp_pkg::out_item_t          mem_r [jcbp_pkg::QUEUE_DEPTH];
  logic [jcbp_pkg::QPTR_W-1:0]  wptr_r, rptr_r;
  logic [jcbp_pkg::QCNT_W-1:0]  cnt_r;

  logic                         take, pop;
  logic                         is_last, valid_ch;
  logic [7:0]                   b, ob;
  jcbp_pkg::err_t               err;
  logic [2:0]                   chan_inc;
  logic [6:0]                   off_inc;
  logic [8:0]                   len_sum;
  logic [1:0]                   k;
  logic [7:0]                   pad_sel;
  jcbp_pkg::out_item_t          res;

  assign cfg_ready = 1'b1;
  assign q_ready   = (cnt_r != jcbp_pkg::QCNT_W'(jcbp_pkg::QUEUE_DEPTH));
  assign take      = q_valid && q_ready;
  assign b         = q_item.item.block_byte;
  assign is_last   = (idx_r == jcbp_pkg::LAST_INDEX);
  assign chan_inc  = (chan_r == 3'd7) ? chan_r : chan_r + 3'd1;
  assign off_inc   = (off_r == 7'd127) ? off_r : off_r + 7'd1;
  assign valid_ch  = (chan_r - 3'd1) < 3'(jcbp_pkg::MAX_CONTROLLERS);
  assign k         = off_r[1:0] - 2'd3;

  always_comb begin
    case (k)
      2'd0:    pad_sel = q_item.item.buttons_high;
      2'd1:    pad_sel = q_item.item.buttons_low;
      2'd2:    pad_sel = q_item.item.stick_x;
      default: pad_sel = q_item.item.stick_y;
    endcase
  end

  always_comb begin
    ob       = b;
    err      = jcbp_pkg::ERR_NONE;
    idx_nxt  = idx_r + 1'b1;
    chan_nxt = chan_r;
    off_nxt  = off_r;
    len_nxt  = len_r;
    kind_nxt = kind_r;
    done_nxt = done_r;
    len_sum  = '0;
    if (!done_r) begin
      if (off_r == '0) begin
        case (q_item.cls)
          jcbp_pkg::CLS_SKIP: begin
            chan_nxt = chan_inc;
            if (chan_inc > 3'd6) begin
              done_nxt = 1'b1;
            end
          end
          jcbp_pkg::CLS_END: begin
            done_nxt = 1'b1;
          end
          jcbp_pkg::CLS_OPEN: begin
            if (chan_r >= 3'(jcbp_pkg::MAX_CONTROLLERS)) begin
              err = jcbp_pkg::ERR_CHANNEL;
            end
            chan_nxt = chan_inc;
            len_sum  = 9'd2 + {1'b0, b};
            len_nxt  = len_sum[8] ? 8'hFF : len_sum[7:0];
            off_nxt  = 7'd1;
          end
          default: begin
          end
        endcase
      end else begin
        if (off_r == 7'd1) begin
          len_sum = {1'b0, len_r} + {1'b0, b & jcbp_pkg::RX_MASK};
          len_nxt = len_sum[8] ? 8'hFF : len_sum[7:0];
        end else if (off_r == 7'd2) begin
          kind_nxt = q_item.kind;
          if (valid_ch && q_item.kind == jcbp_pkg::KIND_OTHER) begin
            err = jcbp_pkg::ERR_UNKNOWN;
          end
        end else if (valid_ch && off_r <= 7'd6) begin
          case (kind_r)
            jcbp_pkg::KIND_INFO: begin
              if (k == 2'd0 && present_r) begin
                ob = jcbp_pkg::ID_BYTE0;
              end else if (k == 2'd1 && present_r) begin
                ob = jcbp_pkg::ID_BYTE1;
              end else if (k == 2'd2) begin
                ob = jcbp_pkg::ID_BYTE2;
              end
            end
            jcbp_pkg::KIND_READ: begin
              ob = present_r ? pad_sel : 8'h00;
            end
            default: begin
            end
          endcase
        end
        off_nxt = ({1'b0, off_inc} >= len_nxt) ? 7'd0 : off_inc;
      end
    end
    if (is_last && q_item.bad_ctrl) begin
      err = jcbp_pkg::ERR_CONTROL;
    end
    if (is_last) begin
      idx_nxt  = '0;
      chan_nxt = '0;
      off_nxt  = '0;
      len_nxt  = '0;
      kind_nxt = jcbp_pkg::KIND_INFO;
      done_nxt = 1'b0;
    end
    res.out_byte   = ob;
    res.error_code = err;
    res.last       = is_last;
  end

  assign out_empty = (cnt_r == '0);
  assign pop       = out_pop && !out_empty;
  assign out_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (take) begin
      mem_r[wptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b1;
      idx_r     <= '0;
      chan_r    <= '0;
      off_r     <= '0;
      len_r     <= '0;
      kind_r    <= jcbp_pkg::KIND_INFO;
      done_r    <= 1'b0;
      wptr_r    <= '0;
      rptr_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        present_r <= cfg_data;
      end
      if (take) begin
        idx_r  <= idx_nxt;
        chan_r <= chan_nxt;
        off_r  <= off_nxt;
        len_r  <= len_nxt;
        kind_r <= kind_nxt;
        done_r <= done_nxt;
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      case ({take, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= jcbp_pkg::QCNT_W'(jcbp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_last) |=> (idx_r == '0 && chan_r == '0 && !done_r))
    else $error("block state not cleared after last byte");

  a_frame_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (off_r != '0) |-> (chan_r != '0))
    else $error("frame open without a channel");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (off_r == '0))
    else $error("frame open after block end");
`endif

endmodule

[sv/joybus_command_block_processor.sv]
// top level of the controller command block processor
//
// channel   direction  handshake          payload
// in_       input      in_push / in_full    jcbp_pkg::in_item_t, one block byte
// out_      output     out_empty / out_pop  jcbp_pkg::out_item_t, one result
// cfg_      input      cfg_valid / cfg_ready controller_present bit
//
// one byte per cycle sustained while the output side does not stall; a byte passes from the
// front queue into the result queue and can be popped from there
// the frame parser in the back end updates its counters once per accepted byte
// two-entry queues on both sides let input and output stall independently
// synchronous reset clears all block state and sets controller_present to 1
module joybus_command_block_processor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  jcbp_pkg::in_item_t   in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output jcbp_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic                 q_valid;
  logic                 q_ready;
  jcbp_pkg::cls_item_t  q_item;

  jcbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  jcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

[bench/tb_joybus_command_block_processor.sv]
// self-checking testbench for the controller command block processor
module tb_joybus_command_block_processor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  class response_tracker;
    jcbp_pkg::out_item_t expected_q[$];
    int errors;
    int checked;
    logic present;
    logic [jcbp_pkg::IDX_W-1:0] byte_idx;
    logic [2:0] chan_count;
    logic [6:0] offset;
    logic [7:0] frame_len;
    logic [7:0] command;
    logic done;

    function new();
      present = 1'b1;
      errors = 0;
      checked = 0;
      clear_block();
    endfunction

    function void clear_block();
      byte_idx = '0;
      chan_count = '0;
      offset = '0;
      frame_len = '0;
      command = '0;
      done = 1'b0;
    endfunction

    function void note_byte(jcbp_pkg::in_item_t it);
      logic [7:0] b;
      logic [7:0] ob;
      logic [7:0] rx_len;
      jcbp_pkg::err_t err;
      logic is_last;
      logic valid_ch;
      int k;
      jcbp_pkg::out_item_t res;
      b = it.block_byte;
      ob = b;
      err = jcbp_pkg::ERR_NONE;
      is_last = (byte_idx == jcbp_pkg::LAST_INDEX);
      if (!done) begin
        if (offset == 7'd0) begin
          if (b == jcbp_pkg::CODE_SKIP) begin
            if (chan_count != 3'd7) chan_count = chan_count + 3'd1;
            if (chan_count > 3'd6) done = 1'b1;
          end else if (b == jcbp_pkg::CODE_END_A || b == jcbp_pkg::CODE_END_B) begin
            done = 1'b1;
          end else if (b == jcbp_pkg::CODE_PAD_A || b == jcbp_pkg::CODE_PAD_B ||
                       b == jcbp_pkg::CODE_PAD_C || b == jcbp_pkg::CODE_PAD_D) begin
            ob = b;
          end else begin
            if (int'(chan_count) >= jcbp_pkg::MAX_CONTROLLERS) err = jcbp_pkg::ERR_CHANNEL;
            if (chan_count != 3'd7) chan_count = chan_count + 3'd1;
            frame_len = (b > 8'd253) ? 8'd255 : b + 8'd2;
            offset = 7'd1;
          end
        end else begin
          valid_ch = (int'(chan_count) - 1) < jcbp_pkg::MAX_CONTROLLERS;
          if (offset == 7'd1) begin
            rx_len = b & jcbp_pkg::RX_MASK;
            frame_len = (int'(frame_len) + int'(rx_len) > 255) ? 8'd255 :
                        frame_len + rx_len;
          end else if (offset == 7'd2) begin
            command = b;
            if (valid_ch && b != jcbp_pkg::CMD_INFO && b != jcbp_pkg::CMD_INFO_B &&
                b != jcbp_pkg::CMD_READ)
              err = jcbp_pkg::ERR_UNKNOWN;
          end else if (valid_ch && offset <= 7'd6) begin
            k = int'(offset) - 3;
            if (command == jcbp_pkg::CMD_INFO || command == jcbp_pkg::CMD_INFO_B) begin
              if (k == 0 && present) ob = jcbp_pkg::ID_BYTE0;
              else if (k == 1 && present) ob = jcbp_pkg::ID_BYTE1;
              else if (k == 2) ob = jcbp_pkg::ID_BYTE2;
            end else if (command == jcbp_pkg::CMD_READ) begin
              ob = 8'h00;
              if (present) begin
                case (k)
                  0: ob = it.buttons_high;
                  1: ob = it.buttons_low;
                  2: ob = it.stick_x;
                  default: ob = it.stick_y;
                endcase
              end
            end
          end
          if (offset != 7'd127) offset = offset + 7'd1;
          if ({1'b0, offset} >= frame_len) offset = 7'd0;
        end
      end
      if (is_last && b > jcbp_pkg::CTRL_MAX && b != jcbp_pkg::CTRL_OK)
        err = jcbp_pkg::ERR_CONTROL;
      res.out_byte = ob;
      res.error_code = err;
      res.last = is_last;
      expected_q.push_back(res);
      if (is_last) clear_block();
      else byte_idx = byte_idx + 1'b1;
    endfunction

    function void check_result(jcbp_pkg::out_item_t got);
      jcbp_pkg::out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte %h err %0d last %b",
                   got.out_byte, got.error_code, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.error_code !== want.error_code ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected byte %h err %0d last %b, got %h err %0d last %b",
                   checked, want.out_byte, want.error_code, want.last,
                   got.out_byte, got.error_code, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  jcbp_pkg::in_item_t in_item;
  logic out_empty;
  logic out_pop;
  jcbp_pkg::out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  response_tracker tracker = new();
  logic [7:0] blk_bytes [jcbp_pkg::BLOCK_BYTES];
  int fill_pos;
  bit idle_on;
  int cycle_count = 0;
  int blocks_sent;
  int bytes_sent;
  int settings_used;

  joybus_command_block_processor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, tracker.expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function void put_byte(logic [7:0] v);
    if (fill_pos < jcbp_pkg::BLOCK_BYTES - 1) blk_bytes[fill_pos] = v;
    fill_pos++;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_byte(input jcbp_pkg::in_item_t it, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    tracker.note_byte(it);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_block();
    jcbp_pkg::in_item_t it;
    for (int i = 0; i < jcbp_pkg::BLOCK_BYTES; i++) begin
      it.block_byte = blk_bytes[i];
      it.buttons_high = $urandom_range(0, 255);
      it.buttons_low = $urandom_range(0, 255);
      it.stick_x = $urandom_range(0, 255);
      it.stick_y = $urandom_range(0, 255);
      push_byte(it, pick_gap());
    end
    blocks_sent++;
  endtask

  task automatic write_present(input logic v);
    in_push <= 1'b0;
    while (tracker.expected_q.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.present = v;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_prefix(input logic [7:0] seq[$]);
    for (int i = 0; i < jcbp_pkg::BLOCK_BYTES; i++) blk_bytes[i] = $urandom_range(0, 255);
    foreach (seq[i]) blk_bytes[i] = seq[i];
  endtask

  task automatic make_block();
    int kind;
    int r;
    int tx;
    int rx;
    logic [7:0] cmd;
    for (int i = 0; i < jcbp_pkg::BLOCK_BYTES; i++) blk_bytes[i] = $urandom_range(0, 255);
    if ($urandom_range(0, 9) != 0) begin
      fill_pos = 0;
      while (fill_pos < jcbp_pkg::BLOCK_BYTES - 1) begin
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          put_byte(jcbp_pkg::CODE_SKIP);
        end else if (kind < 12) begin
          repeat (7) put_byte(jcbp_pkg::CODE_SKIP);
        end else if (kind < 16) begin
          put_byte($urandom_range(0, 1) ? jcbp_pkg::CODE_END_A : jcbp_pkg::CODE_END_B);
          break;
        end else if (kind < 22) begin
          case ($urandom_range(0, 3))
            0: put_byte(jcbp_pkg::CODE_PAD_A);
            1: put_byte(jcbp_pkg::CODE_PAD_B);
            2: put_byte(jcbp_pkg::CODE_PAD_C);
            default: put_byte(jcbp_pkg::CODE_PAD_D);
          endcase
        end else begin
          r = $urandom_range(0, 9);
          if (r < 4) begin
            cmd = jcbp_pkg::CMD_READ;
            tx = 1;
            rx = 4;
          end else if (r < 7) begin
            cmd = $urandom_range(0, 1) ? jcbp_pkg::CMD_INFO : jcbp_pkg::CMD_INFO_B;
            tx = 1;
            rx = 3;
          end else if (r < 9) begin
            cmd = $urandom_range(0, 255);
            tx = $urandom_range(1, 4);
            rx = $urandom_range(0, 8);
          end else begin
            cmd = $urandom_range(0, 3);
            tx = $urandom_range(1, 255);
            rx = $urandom_range(0, 255);
          end
          if ($urandom_range(0, 7) == 0) rx = rx | 8'hC0;
          put_byte(8'(tx));
          put_byte(8'(rx));
          put_byte(cmd);
          fill_pos += tx - 1 + (rx & 8'h3F);
        end
      end
    end
    case ($urandom_range(0, 7))
      0, 1: blk_bytes[jcbp_pkg::LAST_INDEX] = 8'h00;
      2: blk_bytes[jcbp_pkg::LAST_INDEX] = jcbp_pkg::CTRL_MAX;
      3, 4: blk_bytes[jcbp_pkg::LAST_INDEX] = jcbp_pkg::CTRL_OK;
      default: blk_bytes[jcbp_pkg::LAST_INDEX] = $urandom_range(0, 255);
    endcase
  endtask

  initial begin : result_side
    int stall;
    stall = 0;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = pick_gap();
      end
      @(posedge clk);
      if (out_pop && !out_empty) tracker.check_result(out_item);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int blocks_in_phase;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b1;
    blocks_sent = 0;
    bytes_sent = 0;
    settings_used = 0;
    idle_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // info, read, padding, alternate info, unknown command, channel too high, early end
    load_prefix('{8'h01, 8'h03, jcbp_pkg::CMD_INFO, 8'hA5, 8'h5A, 8'hC3,
                  8'h01, 8'h04, jcbp_pkg::CMD_READ, 8'h11, 8'h22, 8'h33, 8'h44,
                  jcbp_pkg::CODE_PAD_A, jcbp_pkg::CODE_PAD_B,
                  jcbp_pkg::CODE_PAD_C, jcbp_pkg::CODE_PAD_D,
                  8'h01, 8'h03, jcbp_pkg::CMD_INFO_B, 8'h00, 8'hFF, 8'h7E,
                  8'h02, 8'h01, 8'h05, 8'h99, 8'h66,
                  8'h01, 8'h00, jcbp_pkg::CMD_READ,
                  jcbp_pkg::CODE_END_B});
    blk_bytes[jcbp_pkg::LAST_INDEX] = 8'hFF;
    send_block();

    // no controller, then five skips close the block
    write_present(1'b0);
    load_prefix('{8'h01, 8'h03, jcbp_pkg::CMD_INFO, 8'hE7, 8'h18, 8'h42,
                  8'h01, 8'h04, jcbp_pkg::CMD_READ, 8'hF0, 8'h0F, 8'hAA, 8'h55,
                  jcbp_pkg::CODE_SKIP, jcbp_pkg::CODE_SKIP, jcbp_pkg::CODE_SKIP,
                  jcbp_pkg::CODE_SKIP, jcbp_pkg::CODE_SKIP,
                  8'h01, 8'h04, jcbp_pkg::CMD_READ});
    blk_bytes[jcbp_pkg::LAST_INDEX] = jcbp_pkg::CTRL_OK;
    send_block();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_present(1'b1);
      else if (ph == 1) write_present(1'b0);
      else write_present(1'($urandom_range(0, 1)));
      idle_on = (ph != 2);
      blocks_in_phase = (ph == 5) ? 4 : 3;
      repeat (blocks_in_phase) begin
        make_block();
        send_block();
      end
    end

    in_push <= 1'b0;
    while (tracker.expected_q.size() > 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("sent %0d block bytes in %0d blocks, checked %0d results", bytes_sent,
             blocks_sent, tracker.checked);
    $display("controller presence written %0d times, %0d mismatches", settings_used,
             tracker.errors);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
